/* rtl/raw_frame_fragment_reassembler_core_assert.svh */
// Assertion helpers shared by the reassembler RTL.
`ifndef RAW_FRAME_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH
`define RAW_FRAME_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH

// Property that must hold in the same cycle.
`define RFFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RFFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rffr_pkg.sv */
`default_nettype none

package rffr_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 11;
  localparam int ADDR_W = 19;
  localparam int LEN_W  = 16;
  localparam int PEER_W = 48;

  localparam int FRAGMENT_BYTES = 1481;
  localparam int PAYLOAD_START  = 19;
  localparam int SRC_FIRST      = 6;
  localparam int SRC_LAST       = 11;
  localparam int LEN_HI_POS     = 15;
  localparam int LEN_LO_POS     = 16;
  localparam int OFFSET_POS     = 17;
  localparam int MORE_POS       = 18;
  localparam int POS_MAX        = 2047;
  localparam int TOTAL_MAX      = 379136;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic [ADDR_W-1:0] message_bytes;
    logic              last_result;
  } rffr_result_t;

endpackage

`default_nettype wire

/* rtl/rffr_in_if.sv */
`default_nettype none

interface rffr_in_if;
  import rffr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/rffr_out_if.sv */
`default_nettype none

interface rffr_out_if;
  import rffr_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [ADDR_W-1:0] write_address;
  logic [BYTE_W-1:0] write_data;
  logic [ADDR_W-1:0] message_bytes;
  logic              last_result;

  modport source (output valid, result_kind, write_address, write_data, message_bytes,
                  last_result, input ready);
  modport sink (input valid, result_kind, write_address, write_data, message_bytes,
                last_result, output ready);
endinterface

`default_nettype wire

/* rtl/raw_frame_fragment_reassembler_core.sv */
`default_nettype none

// Raw frame fragment reassembler. Takes a received Ethernet frame one byte
// per word (frame_last on the final byte) and keeps only frames whose source
// MAC (bytes 6..11) equals peer_address. Bytes 15/16 give the fragment length
// (high byte first, clamped to 1481), byte 17 the fragment offset, byte 18 the
// more flag (nonzero = more). Each payload byte from byte 19 on, up to the
// clamped length, comes out as a write word at offset*1481 + index. At frame
// end the clamped length is added to the message total (saturating at
// 379136); with the more flag clear a completion word carries the total and
// the total clears. A frame ending before byte 18 is dropped. If the final
// byte is also a payload byte of a completing frame, the write word goes out
// before the completion word; last_result marks the final word per input
// byte. Throughput: one input byte per clock while the result queue has
// room. The decode is combinational from the input word straight into a
// four-word result queue; the words a byte causes are registered there and
// offered once earlier words have gone out. Input ready drops only when that
// queue cannot take two more words, i.e. when the output side stalls. The
// user writes peer_address via cfg_write/cfg_data only while idle, unenforced.
module raw_frame_fragment_reassembler_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rffr_pkg::PEER_W-1:0] cfg_data,
  rffr_in_if.sink                     frame,
  rffr_out_if.source                  result
);
  import rffr_pkg::*;

  // per-frame and per-message state
  logic [PEER_W-1:0] peer_address;
  logic [POS_W-1:0]  byte_position;
  logic              source_matches;
  logic [LEN_W-1:0]  fragment_length;
  logic [BYTE_W-1:0] fragment_offset;
  logic              more_follows;
  logic [ADDR_W-1:0] message_total;

  logic              accept;
  logic              room;
  logic [POS_W-1:0]  pos;
  logic              in_src;
  logic [POS_W-1:0]  src_dist;
  logic [2:0]        src_idx;
  logic [BYTE_W-1:0] peer_byte;
  logic              more_now;
  logic [POS_W-1:0]  clamp;
  logic [POS_W-1:0]  payload_idx;
  logic              wr_hit;
  logic              frame_done;
  logic              done_hit;
  logic [ADDR_W-1:0] total_sum;
  logic [ADDR_W-1:0] total_sat;
  logic [ADDR_W-1:0] write_addr;
  rffr_result_t      wr_word, done_word;
  rffr_result_t      data0, data1;
  logic              push0, push1;

  assign accept      = frame.valid && frame.ready;
  assign frame.ready = room;
  assign pos         = byte_position;

  // source MAC compare, byte 6 is the top byte of peer_address
  assign in_src    = pos >= POS_W'(SRC_FIRST) && pos <= POS_W'(SRC_LAST);
  assign src_dist  = POS_W'(SRC_LAST) - pos;
  assign src_idx   = src_dist[2:0];
  assign peer_byte = peer_address[{src_idx, 3'b000} +: BYTE_W];

  // byte 18 sets the flag and may itself be the last byte
  assign more_now = (pos == POS_W'(MORE_POS)) ? (frame.frame_byte != '0) : more_follows;

  assign clamp = (fragment_length > LEN_W'(FRAGMENT_BYTES)) ? POS_W'(FRAGMENT_BYTES)
                                                           : fragment_length[POS_W-1:0];
  assign payload_idx = pos - POS_W'(PAYLOAD_START);

  assign wr_hit = pos >= POS_W'(PAYLOAD_START) && source_matches && payload_idx < clamp;
  assign write_addr = ADDR_W'(fragment_offset) * ADDR_W'(FRAGMENT_BYTES)
                    + ADDR_W'(payload_idx);

  // header complete, frame kept, last byte
  assign frame_done = frame.frame_last && pos >= POS_W'(MORE_POS) && source_matches;
  assign done_hit   = frame_done && !more_now;
  assign total_sum  = message_total + ADDR_W'(clamp);
  assign total_sat  = (total_sum > ADDR_W'(TOTAL_MAX)) ? ADDR_W'(TOTAL_MAX) : total_sum;

  always_comb begin
    wr_word               = '0;
    wr_word.result_kind   = KIND_WRITE;
    wr_word.write_address = write_addr;
    wr_word.write_data    = frame.frame_byte;
    wr_word.last_result   = !done_hit;

    done_word               = '0;
    done_word.result_kind   = KIND_DONE;
    done_word.message_bytes = total_sat;
    done_word.last_result   = 1'b1;
  end

  assign push0 = accept && (wr_hit || done_hit);
  assign push1 = accept && wr_hit && done_hit;
  assign data0 = wr_hit ? wr_word : done_word;
  assign data1 = done_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_address <= '0;
    end else if (cfg_write) begin
      peer_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      source_matches  <= 1'b1;
      fragment_length <= '0;
      fragment_offset <= '0;
      more_follows    <= 1'b0;
      message_total   <= '0;
    end else if (accept) begin
      if (in_src) begin
        if (peer_byte != frame.frame_byte) begin
          source_matches <= 1'b0;
        end
      end else if (pos == POS_W'(LEN_HI_POS)) begin
        fragment_length[LEN_W-1:BYTE_W] <= frame.frame_byte;
      end else if (pos == POS_W'(LEN_LO_POS)) begin
        fragment_length[BYTE_W-1:0] <= frame.frame_byte;
      end else if (pos == POS_W'(OFFSET_POS)) begin
        fragment_offset <= frame.frame_byte;
      end else if (pos == POS_W'(MORE_POS)) begin
        more_follows <= frame.frame_byte != '0;
      end

      if (frame.frame_last) begin
        if (frame_done) begin
          message_total <= more_now ? total_sat : '0;
        end
        byte_position  <= '0;
        source_matches <= 1'b1;
      end else if (pos < POS_W'(POS_MAX)) begin
        byte_position <= pos + POS_W'(1);
      end
    end
  end

  rffr_result_fifo u_result_fifo (
    .clk    (clk),
    .rst    (rst),
    .push0  (push0),
    .data0  (data0),
    .push1  (push1),
    .data1  (data1),
    .room   (room),
    .result (result)
  );

  `RFFR_ASSERT(a_push_room, clk, rst, !push0 || room, "result pushed without queue room")
  `RFFR_ASSERT(a_pair_at_end, clk, rst, !push1 || frame.frame_last, "two words mid-frame")
  `RFFR_ASSERT(a_total_bound, clk, rst, message_total <= ADDR_W'(TOTAL_MAX), "total too big")
  `RFFR_ASSERT_NEXT(a_pos_clear, clk, rst, accept && frame.frame_last, byte_position == '0,
                    "position not cleared at frame end")

endmodule

`default_nettype wire

/* rtl/rffr_result_fifo.sv */
`default_nettype none

`include "raw_frame_fragment_reassembler_core_assert.svh"

// Small result queue: takes up to two words per cycle, hands out one.
module rffr_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push0,
  input  rffr_pkg::rffr_result_t data0,
  input  logic                  push1,
  input  rffr_pkg::rffr_result_t data1,
  output logic                  room,
  rffr_out_if.source            result
);
  import rffr_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rffr_result_t      mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PTR_W-1:0]  wr_ptr_plus1;
  logic              pop;
  rffr_result_t      head;

  assign pop          = result.valid && result.ready;
  assign wr_ptr_plus1 = wr_ptr + PTR_W'(1);
  assign wr_ptr_next  = wr_ptr + PTR_W'(push0) + PTR_W'(push1);
  assign rd_ptr_next  = rd_ptr + PTR_W'(pop);
  assign count_next   = count + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
  // room for a write plus a completion
  assign room         = count <= CNT_W'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push0 && wr_ptr == PTR_W'(i)) begin
        mem[i] <= data0;
      end else if (push1 && wr_ptr_plus1 == PTR_W'(i)) begin
        mem[i] <= data1;
      end
    end
  end

  assign head                 = mem[rd_ptr];
  assign result.valid         = count != '0;
  assign result.result_kind   = head.result_kind;
  assign result.write_address = head.write_address;
  assign result.write_data    = head.write_data;
  assign result.message_bytes = head.message_bytes;
  assign result.last_result   = head.last_result;

  `RFFR_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "result queue overfilled")
  `RFFR_ASSERT(a_push_order, clk, rst, !push1 || push0, "second word pushed without first")
  `RFFR_ASSERT_NEXT(a_empty_stays, clk, rst, count == '0 && !push0, !result.valid, "phantom word")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

// Frame reassembler testbench: frames are built byte by byte, and every
// accepted byte is run through a local copy of the reassembly logic. That
// copy queues the words the block should produce, and the result monitor
// compares each output word against the oldest queued one.
module tb;
  import rffr_pkg::*;

  // Quiet cycles allowed before the run is declared hung. The longest legal
  // quiet stretch is the receiver hold-off (HOLD_CYCLES) plus a sender gap.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  // Decode feeds the four-word queue directly; idle margin after the drain.
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_WORDS    = 250;
  localparam int NUM_PHASES     = 4;
  localparam int MAX_REPORTS    = 50;

  // How a frame's source address relates to the configured peer.
  typedef enum logic [1:0] {FRM_MATCH, FRM_FOREIGN, FRM_NOISE} frame_mode_t;

  typedef struct {
    frame_mode_t mode;
    logic [15:0] len;     // length field, bytes 15/16
    logic [7:0]  off;     // fragment offset, byte 17
    logic [7:0]  more;    // more flag byte, byte 18
    int          nbytes;  // frame size in bytes
    int          copies;
    int          total;   // completion total read off by hand, -1 = predicted
  } frame_row_t;

  // Directed frames. The peer is still at its reset value (all zero) here.
  frame_row_t directed_frames [12] = '{
    // header only, zero length, completes at once
    '{FRM_MATCH,   16'd0,     8'd0,   8'd0,   19,   1,   0},
    // three payload bytes; the final byte is a write and a completion
    '{FRM_MATCH,   16'd3,     8'd0,   8'd0,   22,   1,   3},
    // single byte frame
    '{FRM_MATCH,   16'd0,     8'd0,   8'd0,   1,    1,   -1},
    // ends just short of the more flag: dropped
    '{FRM_MATCH,   16'd4,     8'd0,   8'd0,   18,   1,   -1},
    // wrong source: no words at all
    '{FRM_FOREIGN, 16'd4,     8'd0,   8'd0,   23,   1,   -1},
    // top offset, payload longer than the length field
    '{FRM_MATCH,   16'd5,     8'hFF,  8'd1,   25,   1,   -1},
    // payload shorter than the length field, flag set by its top bit
    '{FRM_MATCH,   16'd10,    8'd1,   8'h80,  24,   1,   -1},
    // max length clamps to 1481: 5 + 10 + 1481
    '{FRM_MATCH,   16'hFFFF,  8'd0,   8'd0,   23,   1,   1496},
    // one over the clamp, more set
    '{FRM_MATCH,   16'd1482,  8'd3,   8'd1,   30,   1,   -1},
    // header only frame closes the clamped fragment above
    '{FRM_MATCH,   16'd0,     8'd0,   8'd0,   19,   1,   FRAGMENT_BYTES},
    '{FRM_MATCH,   16'd256,   8'hAA,  8'd1,   19,   1,   -1},
    '{FRM_MATCH,   16'd1,     8'd0,   8'd0,   20,   1,   257}
  };

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [PEER_W-1:0] cfg_data;

  rffr_in_if  frame_if ();
  rffr_out_if result_if ();

  raw_frame_fragment_reassembler_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .frame     (frame_if),
    .result    (result_if)
  );

  always #5 clk = ~clk;

  // Local copy of the reassembly state.
  logic [PEER_W-1:0] peer_addr;
  logic [POS_W-1:0]  byte_pos;
  logic              src_match;
  logic [LEN_W-1:0]  frag_len;
  logic [7:0]        frag_off;
  logic              more_set;
  logic [ADDR_W-1:0] msg_total;

  rffr_result_t expected_words [$];
  rffr_result_t head_word;

  int mismatches  = 0;
  int words_sent  = 0;
  int quiet_cycles = 0;

  // Sender burst/gap control.
  int burst_left = 0;
  bit idle_on    = 1'b0;

  // Receiver stall control; hold_req asks the receiver for a long hold-off.
  bit rx_stall_on = 1'b0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] MISMATCH %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Advance the reassembly state by one byte; returns how many output words
  // the byte causes (0..2), in order, through w0/w1.
  function automatic int reassemble_word(input logic [7:0] b, input logic last,
                                         output rffr_result_t w0,
                                         output rffr_result_t w1);
    rffr_result_t res [2];
    int           n;
    int           pos;
    int           idx;
    int           clen;
    int           sum;
    n = 0;
    pos = int'(byte_pos);
    res[0] = '0;
    res[1] = '0;

    if (pos >= SRC_FIRST && pos <= SRC_LAST) begin
      if (peer_addr[8*(SRC_LAST-pos) +: 8] != b)
        src_match = 1'b0;
    end else if (pos == LEN_HI_POS) begin
      frag_len[15:8] = b;
    end else if (pos == LEN_LO_POS) begin
      frag_len[7:0] = b;
    end else if (pos == OFFSET_POS) begin
      frag_off = b;
    end else if (pos == MORE_POS) begin
      more_set = (b != 8'd0);
    end

    clen = (int'(frag_len) > FRAGMENT_BYTES) ? FRAGMENT_BYTES : int'(frag_len);

    // payload write, stopped at the clamped length
    if (pos >= PAYLOAD_START && src_match) begin
      idx = pos - PAYLOAD_START;
      if (idx < clen) begin
        res[n].result_kind   = KIND_WRITE;
        res[n].write_address = ADDR_W'(int'(frag_off) * FRAGMENT_BYTES + idx);
        res[n].write_data    = b;
        n++;
      end
    end

    if (last) begin
      // frames that end before the more flag never count
      if (pos >= MORE_POS && src_match) begin
        sum = int'(msg_total) + clen;
        msg_total = ADDR_W'((sum > TOTAL_MAX) ? TOTAL_MAX : sum);
        if (!more_set) begin
          res[n].result_kind   = KIND_DONE;
          res[n].message_bytes = msg_total;
          n++;
          msg_total = '0;
        end
      end
      byte_pos  = '0;
      src_match = 1'b1;
    end else if (pos < POS_MAX) begin
      byte_pos = byte_pos + POS_W'(1);
    end

    if (n > 0)
      res[n-1].last_result = 1'b1;
    w0 = res[0];
    w1 = res[1];
    return n;
  endfunction

  // Offer one byte, wait for the handshake, then queue what it should cause.
  // A non-negative fixed_total replaces the predicted completion word.
  task automatic send_word(input logic [7:0] b, input logic last,
                           input int fixed_total);
    rffr_result_t w [3];
    int           n;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        frame_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    frame_if.valid      <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.frame_last <= last;
    do @(posedge clk); while (!frame_if.ready);
    words_sent++;

    n = reassemble_word(b, last, w[0], w[1]);
    if (fixed_total >= 0) begin
      if (n > 0 && w[n-1].result_kind == KIND_DONE)
        n--;
      if (n > 0)
        w[n-1].last_result = 1'b0;
      w[n] = '0;
      w[n].result_kind   = KIND_DONE;
      w[n].message_bytes = ADDR_W'(fixed_total);
      w[n].last_result   = 1'b1;
      n++;
    end
    for (int i = 0; i < n; i++)
      expected_words.push_back(w[i]);
  endtask

  task automatic send_frame(input frame_mode_t mode, input logic [15:0] len,
                            input logic [7:0] off, input logic [7:0] more,
                            input int nbytes, input int fixed_total);
    int         bad_pos;
    int         p;
    logic [7:0] b;
    bad_pos = $urandom_range(SRC_FIRST, SRC_LAST);
    for (p = 0; p < nbytes; p++) begin
      b = 8'($urandom);
      if (mode != FRM_NOISE) begin
        if (p >= SRC_FIRST && p <= SRC_LAST) begin
          b = peer_addr[8*(SRC_LAST-p) +: 8];
          if (mode == FRM_FOREIGN && p == bad_pos)
            b = b ^ 8'($urandom_range(1, 255));
        end else if (p == LEN_HI_POS) begin
          b = len[15:8];
        end else if (p == LEN_LO_POS) begin
          b = len[7:0];
        end else if (p == OFFSET_POS) begin
          b = off;
        end else if (p == MORE_POS) begin
          b = more;
        end
      end
      send_word(b, p == nbytes - 1, (p == nbytes - 1) ? fixed_total : -1);
    end
  endtask

  // Mostly well-formed frames from the peer with random content; the rest
  // are foreign sources, truncated headers and plain noise.
  task automatic random_frame();
    int          sel;
    int          n;
    logic [15:0] len;
    logic [7:0]  more;
    sel = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(0, 30);
    case ($urandom_range(0, 5))
      0, 1: len = 16'(n);
      2:    len = 16'(n + $urandom_range(1, 8));
      3:    len = (n > 0) ? 16'($urandom_range(0, n - 1)) : 16'd0;
      4:    len = 16'($urandom);
      default: len = 16'(FRAGMENT_BYTES + $urandom_range(0, 2));
    endcase
    more = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    if (sel < 70)
      send_frame(FRM_MATCH, len, 8'($urandom), more, PAYLOAD_START + n, -1);
    else if (sel < 80)
      send_frame(FRM_FOREIGN, len, 8'($urandom), more, PAYLOAD_START + n, -1);
    else if (sel < 90)
      send_frame(FRM_MATCH, len, 8'($urandom), more, $urandom_range(1, MORE_POS), -1);
    else
      send_frame(FRM_NOISE, len, 8'($urandom), more, $urandom_range(1, 60), -1);
  endtask

  // Stop offering, let every queued word drain, then give the decode stage
  // time to settle before anything touches the register.
  task automatic settle_idle();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_peer(input logic [PEER_W-1:0] value);
    settle_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    peer_addr = value;
  endtask

  // Receiver ready: optional long hold-off, then random short stalls.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 99) < 15) begin
      stall_left = $urandom_range(0, 7);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Result monitor: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d addr=%0d data=%0d total=%0d",
                                  result_if.result_kind, result_if.write_address,
                                  result_if.write_data, result_if.message_bytes));
      end else begin
        head_word = expected_words.pop_front();
        check_field("result_kind", result_if.result_kind, head_word.result_kind);
        check_field("write_address", result_if.write_address, head_word.write_address);
        check_field("write_data", result_if.write_data, head_word.write_data);
        check_field("message_bytes", result_if.message_bytes, head_word.message_bytes);
        check_field("last_result", result_if.last_result, head_word.last_result);
      end
    end
  end

  // Watchdog: any accepted word on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [PEER_W-1:0] phase_peer;
    int                phase_start;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    frame_if.valid      = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.frame_last = 1'b0;
    result_if.ready     = 1'b0;

    // reset state of the local copy
    peer_addr = '0;
    byte_pos  = '0;
    src_match = 1'b1;
    frag_len  = '0;
    frag_off  = '0;
    more_set  = 1'b0;
    msg_total = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames, light idling on both sides
    idle_on     = 1'b1;
    rx_stall_on = 1'b1;
    foreach (directed_frames[i])
      for (int k = 0; k < directed_frames[i].copies; k++)
        send_frame(directed_frames[i].mode, directed_frames[i].len, directed_frames[i].off,
                   directed_frames[i].more, directed_frames[i].nbytes,
                   directed_frames[i].total);

    // random phases, each under its own peer address
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       phase_peer = {PEER_W{1'b1}};
        2:       phase_peer = '0;
        default: phase_peer = {16'($urandom), $urandom};
      endcase
      write_peer(phase_peer);
      // first phase runs flat out on both sides
      idle_on     = (ph != 0);
      rx_stall_on = (ph != 0);
      phase_start = words_sent;
      if (ph == 1) begin
        // receiver holds off while a long fragment keeps coming, so the
        // result queue fills and input ready drops
        hold_req = 1'b1;
        send_frame(FRM_MATCH, 16'd200, 8'($urandom), 8'd0, PAYLOAD_START + 200, -1);
      end
      while (words_sent - phase_start < PHASE_WORDS)
        random_frame();
    end

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
